// ----- sv/repressilator_euler_step_defines.svh -----
// assertion macros for the repressilator euler stepper checker
// depends on nothing; the including module must have clock and reset
`ifndef REPRESSILATOR_EULER_STEP_DEFINES_SVH
`define REPRESSILATOR_EULER_STEP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define REP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("repressilator check failed");

// next-cycle implication, disabled during reset
`define REP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("repressilator check failed");

`endif

// ----- sv/rep_pkg.sv -----
// shared types, constants and helpers for the repressilator euler stepper
// no dependencies
package rep_pkg;

   localparam int LEVEL_W = 48;
   localparam int RATE_W  = 47;
   localparam int STEP_W  = 37;
   localparam int COUNT_W = 32;
   localparam int FRAC_W  = 36;
   localparam int MAG_W   = 60;
   localparam int MULB_W  = 48;
   localparam int DEN_W   = 60;
   localparam int QUO_W   = 47;
   localparam int PROD_W  = 64;

   localparam logic [RATE_W-1:0] MAX_RATE_RST    = 47'd14843406974976;
   localparam logic [RATE_W-1:0] LEAK_RATE_RST   = 47'd14843406975;
   localparam logic [RATE_W-1:0] DECAY_RATIO_RST = 47'd20615843021;
   localparam logic [STEP_W-1:0] STEP_SIZE_RST   = 37'd6871948;
   localparam logic signed [LEVEL_W-1:0] MRNA_35_RST = 48'sd2405181685760;

   localparam logic signed [PROD_W-1:0] LEVEL_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [PROD_W-1:0] LEVEL_MIN = 64'shFFFF_8000_0000_0000;

   typedef logic signed [LEVEL_W-1:0] level_type;

   typedef enum logic [1:0] {
      CSR_MAX_RATE    = 2'd0,
      CSR_LEAK_RATE   = 2'd1,
      CSR_DECAY_RATIO = 2'd2,
      CSR_STEP_SIZE   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ_GO, ST_SQ_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_DM_GO, ST_DM_WAIT,
      ST_DP_GO, ST_DP_WAIT, ST_DH_GO, ST_DH_WAIT, ST_COMMIT, ST_FINISH
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_LOAD, CMD_SQ, CMD_DIV, CMD_DM, CMD_DP, CMD_DH, CMD_COMMIT, CMD_OUT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic       go;
      logic [1:0] gene;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
   } status_type;

   // clamp a wide signed sum to the level range
   function automatic level_type sat_level(input logic signed [PROD_W-1:0] v);
      level_type r;
      if (v > LEVEL_MAX) begin
         r = LEVEL_MAX[LEVEL_W-1:0];
      end else if (v < LEVEL_MIN) begin
         r = LEVEL_MIN[LEVEL_W-1:0];
      end else begin
         r = v[LEVEL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/rep_mul.sv -----
// iterative fixed-point multiplier: 60 x 48 magnitude in six 20 x 24 partial products
// result is the signed product shifted right by the fraction width with floor rounding
// depends on rep_pkg
module rep_mul import rep_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     go,
   input  logic                     a_neg,
   input  logic [MAG_W-1:0]         a_mag,
   input  logic [MULB_W-1:0]        b_val,
   output logic                     done,
   output logic signed [PROD_W-1:0] product
);

   localparam int ACC_W = MAG_W + MULB_W;
   localparam logic [2:0] LAST = 3'd6;

   logic [MAG_W-1:0]  a_ff;
   logic [MULB_W-1:0] b_ff;
   logic              neg_ff;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [2:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic [19:0]      a_part;
   logic [23:0]      b_part;
   logic [6:0]       shift;
   logic [43:0]      pp;
   logic signed [ACC_W:0] sacc;
   logic signed [ACC_W:0] sshift;

   // partial product selection
   always_comb begin
      case (cnt_ff)
         3'd0: begin a_part = a_ff[19:0];  b_part = b_ff[23:0];  shift = 7'd0;  end
         3'd1: begin a_part = a_ff[19:0];  b_part = b_ff[47:24]; shift = 7'd24; end
         3'd2: begin a_part = a_ff[39:20]; b_part = b_ff[23:0];  shift = 7'd20; end
         3'd3: begin a_part = a_ff[39:20]; b_part = b_ff[47:24]; shift = 7'd44; end
         3'd4: begin a_part = a_ff[59:40]; b_part = b_ff[23:0];  shift = 7'd40; end
         3'd5: begin a_part = a_ff[59:40]; b_part = b_ff[47:24]; shift = 7'd64; end
         default: begin a_part = '0; b_part = '0; shift = 7'd0; end
      endcase
      pp     = 44'(a_part) * 44'(b_part);
      acc_in = acc_ff + (ACC_W'(pp) << shift);
   end

   // apply sign and floor shift
   always_comb begin
      sacc    = neg_ff ? -$signed({1'b0, acc_ff}) : $signed({1'b0, acc_ff});
      sshift  = sacc >>> FRAC_W;
      prod_in = sshift[PROD_W-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (go) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end else begin
            cnt_ff  <= cnt_ff + 3'd1;
            done_ff <= 1'b0;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // operands and accumulator
   always_ff @(posedge clock) begin
      if (go) begin
         a_ff   <= a_mag;
         b_ff   <= b_val;
         neg_ff <= a_neg;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (cnt_ff == LAST) begin
            prod_ff <= prod_in;
         end else begin
            acc_ff <= acc_in;
         end
      end
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

// ----- sv/rep_div.sv -----
// restoring divider, one quotient bit a cycle: floor(num * 2^36 / den)
// den is at least one in fixed point so the quotient fits 47 bits
// depends on rep_pkg
module rep_div import rep_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             go,
   input  logic [QUO_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [QUO_W-1:0] quo
);

   localparam int HI_W = QUO_W - FRAC_W;
   localparam logic [5:0] LAST = 6'(QUO_W - 1);

   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [QUO_W-1:0] sh_ff;
   logic [QUO_W-1:0] quo_ff;
   logic [5:0]       cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DEN_W:0] trial;
   logic [DEN_W:0] diff;
   logic           fits;

   // trial subtract
   always_comb begin
      trial = {rem_ff, sh_ff[QUO_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (go) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   // remainder and quotient
   always_ff @(posedge clock) begin
      if (go) begin
         rem_ff <= DEN_W'(num[QUO_W-1:HI_W]);
         sh_ff  <= {num[HI_W-1:0], FRAC_W'(0)};
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         sh_ff  <= {sh_ff[QUO_W-2:0], 1'b0};
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ----- sv/rep_dp.sv -----
// datapath: levels, registers, step counter, output registers and the arithmetic units
// depends on rep_pkg, rep_mul, rep_div
module rep_dp import rep_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [RATE_W-1:0]   csr_wdata,
   input  level_type           req_load_mrna_a,
   input  level_type           req_load_mrna_b,
   input  level_type           req_load_mrna_c,
   input  level_type           req_load_protein_a,
   input  level_type           req_load_protein_b,
   input  level_type           req_load_protein_c,
   output logic [COUNT_W-1:0]  rsp_step_index,
   output level_type           rsp_mrna_a,
   output level_type           rsp_mrna_b,
   output level_type           rsp_mrna_c,
   output level_type           rsp_protein_a,
   output level_type           rsp_protein_b,
   output level_type           rsp_protein_c
);

   localparam logic [DEN_W-1:0] ONE_Q = DEN_W'(1) << FRAC_W;

   logic [RATE_W-1:0]  max_rate_ff, leak_rate_ff, decay_ratio_ff;
   logic [STEP_W-1:0]  step_size_ff;
   level_type          mrna_ff [3];
   level_type          protein_ff [3];
   level_type          new_mrna_ff [3];
   level_type          new_protein_ff [3];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] out_count_ff;
   level_type          out_mrna_ff [3];
   level_type          out_protein_ff [3];

   level_type             cur_m, cur_p, rep_p;
   logic [LEVEL_W-1:0]    rep_mag;
   logic signed [49:0]    dm;
   logic [49:0]           dm_mag;
   logic signed [48:0]    diff;
   logic [48:0]           diff_mag;
   logic [MAG_W-1:0]      dp_mag;
   logic [DEN_W-1:0]      den;
   logic                  mul_go, mul_neg, mul_done;
   logic [MAG_W-1:0]      mul_a;
   logic [MULB_W-1:0]     mul_b;
   logic signed [PROD_W-1:0] mul_prod;
   logic                  div_go, div_done;
   logic [QUO_W-1:0]      div_quo;

   // gene operands; gene a is repressed by protein c
   always_comb begin
      case (cmd.gene)
         2'd0: begin cur_m = mrna_ff[0]; cur_p = protein_ff[0]; rep_p = protein_ff[2]; end
         2'd1: begin cur_m = mrna_ff[1]; cur_p = protein_ff[1]; rep_p = protein_ff[0]; end
         2'd2: begin cur_m = mrna_ff[2]; cur_p = protein_ff[2]; rep_p = protein_ff[1]; end
         default: begin cur_m = '0; cur_p = '0; rep_p = '0; end
      endcase
   end

   // derivative terms
   always_comb begin
      rep_mag  = rep_p[LEVEL_W-1] ? LEVEL_W'(-rep_p) : LEVEL_W'(rep_p);
      den      = ONE_Q + DEN_W'(mul_prod[58:0]);
      dm       = $signed({3'b000, div_quo}) + $signed({3'b000, leak_rate_ff}) - 50'(cur_m);
      dm_mag   = dm[49] ? 50'(-dm) : 50'(dm);
      diff     = 49'(cur_m) - 49'(cur_p);
      diff_mag = diff[48] ? 49'(-diff) : 49'(diff);
      dp_mag   = mul_prod[PROD_W-1] ? MAG_W'(-mul_prod) : MAG_W'(mul_prod);
   end

   // multiplier operand select
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (cmd.op)
         CMD_SQ: begin
            mul_a = MAG_W'(rep_mag);
            mul_b = rep_mag;
         end
         CMD_DM: begin
            mul_a   = MAG_W'(dm_mag);
            mul_b   = MULB_W'(step_size_ff);
            mul_neg = dm[49];
         end
         CMD_DP: begin
            mul_a   = MAG_W'(diff_mag);
            mul_b   = MULB_W'(decay_ratio_ff);
            mul_neg = diff[48];
         end
         CMD_DH: begin
            mul_a   = dp_mag;
            mul_b   = MULB_W'(step_size_ff);
            mul_neg = mul_prod[PROD_W-1];
         end
         default: begin
            mul_a = '0;
         end
      endcase
      mul_go = cmd.go && (cmd.op == CMD_SQ || cmd.op == CMD_DM ||
                          cmd.op == CMD_DP || cmd.op == CMD_DH);
      div_go = cmd.go && (cmd.op == CMD_DIV);
   end

   rep_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .go      (mul_go),
      .a_neg   (mul_neg),
      .a_mag   (mul_a),
      .b_val   (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   rep_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (max_rate_ff),
      .den   (den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign status.mul_done = mul_done;
   assign status.div_done = div_done;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_rate_ff    <= MAX_RATE_RST;
         leak_rate_ff   <= LEAK_RATE_RST;
         decay_ratio_ff <= DECAY_RATIO_RST;
         step_size_ff   <= STEP_SIZE_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAX_RATE:    max_rate_ff    <= csr_wdata;
            CSR_LEAK_RATE:   leak_rate_ff   <= csr_wdata;
            CSR_DECAY_RATIO: decay_ratio_ff <= csr_wdata;
            CSR_STEP_SIZE:   step_size_ff   <= csr_wdata[STEP_W-1:0];
            default:         max_rate_ff    <= max_rate_ff;
         endcase
      end
   end

   // levels and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         mrna_ff[0]    <= '0;
         mrna_ff[1]    <= MRNA_35_RST;
         mrna_ff[2]    <= MRNA_35_RST;
         protein_ff[0] <= '0;
         protein_ff[1] <= '0;
         protein_ff[2] <= '0;
         count_ff      <= '0;
      end else begin
         case (cmd.op)
            CMD_LOAD: begin
               mrna_ff[0]    <= req_load_mrna_a;
               mrna_ff[1]    <= req_load_mrna_b;
               mrna_ff[2]    <= req_load_mrna_c;
               protein_ff[0] <= req_load_protein_a;
               protein_ff[1] <= req_load_protein_b;
               protein_ff[2] <= req_load_protein_c;
               count_ff      <= '0;
            end
            CMD_COMMIT: begin
               mrna_ff    <= new_mrna_ff;
               protein_ff <= new_protein_ff;
               if (count_ff != '1) begin
                  count_ff <= count_ff + COUNT_W'(1);
               end
            end
            default: begin
               count_ff <= count_ff;
            end
         endcase
      end
   end

   // new levels, all from the old ones
   always_ff @(posedge clock) begin
      if (mul_done && cmd.op == CMD_DM) begin
         new_mrna_ff[cmd.gene] <= sat_level(PROD_W'(cur_m) + mul_prod);
      end
      if (mul_done && cmd.op == CMD_DH) begin
         new_protein_ff[cmd.gene] <= sat_level(PROD_W'(cur_p) + mul_prod);
      end
   end

   // output registers
   always_ff @(posedge clock) begin
      if (cmd.op == CMD_OUT) begin
         out_count_ff   <= count_ff;
         out_mrna_ff    <= mrna_ff;
         out_protein_ff <= protein_ff;
      end
   end

   assign rsp_step_index = out_count_ff;
   assign rsp_mrna_a     = out_mrna_ff[0];
   assign rsp_mrna_b     = out_mrna_ff[1];
   assign rsp_mrna_c     = out_mrna_ff[2];
   assign rsp_protein_a  = out_protein_ff[0];
   assign rsp_protein_b  = out_protein_ff[1];
   assign rsp_protein_c  = out_protein_ff[2];

endmodule

// ----- sv/rep_ctrl.sv -----
// controller: a step runs square, divide and multiplies per gene, then commit and output; a load goes to output
// depends on rep_pkg
module rep_ctrl import rep_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_kind,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] gene_ff, gene_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      gene_in  = gene_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_kind ? ST_FINISH : ST_SQ_GO;
               gene_in  = 2'd0;
            end
         end
         ST_SQ_GO:    state_in = ST_SQ_WAIT;
         ST_SQ_WAIT:  if (status.mul_done) state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (status.div_done) state_in = ST_DM_GO;
         ST_DM_GO:    state_in = ST_DM_WAIT;
         ST_DM_WAIT:  if (status.mul_done) state_in = ST_DP_GO;
         ST_DP_GO:    state_in = ST_DP_WAIT;
         ST_DP_WAIT:  if (status.mul_done) state_in = ST_DH_GO;
         ST_DH_GO:    state_in = ST_DH_WAIT;
         ST_DH_WAIT: begin
            if (status.mul_done) begin
               if (gene_ff == 2'd2) begin
                  state_in = ST_COMMIT;
               end else begin
                  state_in = ST_SQ_GO;
                  gene_in  = gene_ff + 2'd1;
               end
            end
         end
         ST_COMMIT:   state_in = ST_FINISH;
         ST_FINISH:   if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs and commands
   always_comb begin
      cmd.op       = CMD_NONE;
      cmd.go       = 1'b0;
      cmd.gene     = gene_ff;
      req_stall    = (state_ff != ST_IDLE);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE:     if (req_valid && req_kind) cmd.op = CMD_LOAD;
         ST_SQ_GO:    begin cmd.op = CMD_SQ;  cmd.go = 1'b1; end
         ST_SQ_WAIT:  cmd.op = CMD_SQ;
         ST_DIV_GO:   begin cmd.op = CMD_DIV; cmd.go = 1'b1; end
         ST_DIV_WAIT: cmd.op = CMD_DIV;
         ST_DM_GO:    begin cmd.op = CMD_DM;  cmd.go = 1'b1; end
         ST_DM_WAIT:  cmd.op = CMD_DM;
         ST_DP_GO:    begin cmd.op = CMD_DP;  cmd.go = 1'b1; end
         ST_DP_WAIT:  cmd.op = CMD_DP;
         ST_DH_GO:    begin cmd.op = CMD_DH;  cmd.go = 1'b1; end
         ST_DH_WAIT:  cmd.op = CMD_DH;
         ST_COMMIT:   cmd.op = CMD_COMMIT;
         ST_FINISH: begin
            if (out_free) begin
               cmd.op       = CMD_OUT;
               rsp_valid_in = 1'b1;
            end
         end
         default:     cmd.op = CMD_NONE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gene_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gene_ff      <= gene_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/repressilator_euler_step.sv -----
// Repressilator forward Euler stepper. For a step item each of the three genes runs a
// square of its repressor, a divide (one quotient bit a cycle) and three multiplies, all
// on one shared multiplier and one divider, then a commit and an output. A load item
// goes straight to the output. One item is worked on at a time; the finished item sits
// in an output register, so the next item is taken while it waits. Registers are written
// through the csr port at any time the block is idle; csr_ready is always high.
// depends on rep_pkg, rep_ctrl, rep_dp
module repressilator_euler_step import rep_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_kind,
   input  level_type           req_load_mrna_a,
   input  level_type           req_load_mrna_b,
   input  level_type           req_load_mrna_c,
   input  level_type           req_load_protein_a,
   input  level_type           req_load_protein_b,
   input  level_type           req_load_protein_c,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COUNT_W-1:0]  rsp_step_index,
   output level_type           rsp_mrna_a,
   output level_type           rsp_mrna_b,
   output level_type           rsp_mrna_c,
   output level_type           rsp_protein_a,
   output level_type           rsp_protein_b,
   output level_type           rsp_protein_c,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [RATE_W-1:0]   csr_wdata
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   rep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rep_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_load_mrna_a    (req_load_mrna_a),
      .req_load_mrna_b    (req_load_mrna_b),
      .req_load_mrna_c    (req_load_mrna_c),
      .req_load_protein_a (req_load_protein_a),
      .req_load_protein_b (req_load_protein_b),
      .req_load_protein_c (req_load_protein_c),
      .rsp_step_index     (rsp_step_index),
      .rsp_mrna_a         (rsp_mrna_a),
      .rsp_mrna_b         (rsp_mrna_b),
      .rsp_mrna_c         (rsp_mrna_c),
      .rsp_protein_a      (rsp_protein_a),
      .rsp_protein_b      (rsp_protein_b),
      .rsp_protein_c      (rsp_protein_c)
   );

endmodule

// ----- sv/rep_checker.sv -----
// port-level checker for the repressilator euler stepper, bound to the top level
// depends on repressilator_euler_step_defines.svh
`include "repressilator_euler_step_defines.svh"

module rep_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic csr_ready
);

   // an accepted item keeps the block busy on the next cycle
   `REP_ASSERT_NEXT(busy_after_accept, req_valid && !req_stall, req_stall)
   // a new result appears as the block returns to idle
   `REP_ASSERT_NOW(idle_with_new_result, $rose(rsp_valid), !req_stall)
   // the register port never back-pressures
   `REP_ASSERT_NOW(csr_always_ready, 1'b1, csr_ready)
   // a stalled result stays offered
   `REP_ASSERT_NEXT(rsp_held, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind repressilator_euler_step rep_checker u_rep_checker (.*);

// ----- dv/repressilator_euler_step_test.sv -----
// self-checking testbench for the repressilator forward euler stepper
// depends on rep_pkg and repressilator_euler_step; predicts every result in Q12.36
module repressilator_euler_step_test;
   import rep_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 20000;
   localparam int PHASE_ITEMS = 225;

   typedef struct {
      logic      kind;
      level_type lm[3];
      level_type lp[3];
   } gene_item_type;

   typedef struct {
      logic [COUNT_W-1:0] idx;
      level_type          m[3];
      level_type          p[3];
   } levels_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_kind = 1'b0;
   level_type req_load_mrna_a = '0, req_load_mrna_b = '0, req_load_mrna_c = '0;
   level_type req_load_protein_a = '0, req_load_protein_b = '0, req_load_protein_c = '0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [COUNT_W-1:0] rsp_step_index;
   level_type rsp_mrna_a, rsp_mrna_b, rsp_mrna_c;
   level_type rsp_protein_a, rsp_protein_b, rsp_protein_c;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [RATE_W-1:0] csr_wdata = '0;

   repressilator_euler_step dut (.*);

   always #5 clock = ~clock;

   // shadow state and registers of the stepper
   level_type mrna_lvl[3];
   level_type prot_lvl[3];
   logic [COUNT_W-1:0] step_count;
   logic [RATE_W-1:0] alpha, alpha0, beta;
   logic [STEP_W-1:0] h_step;

   gene_item_type pending_items[$];
   levels_type expected_levels[$];
   gene_item_type cur_item;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int errors = 0;
   int quiet_cycles = 0;

   // floor(a*b / 2^36), magnitude capped at 2^62
   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                 input logic [63:0] b);
      logic [63:0] mag;
      logic [127:0] prod;
      logic [127:0] q;
      logic signed [63:0] r;
      mag = a[63] ? 64'd0 - a : a;
      prod = {64'd0, mag} * {64'd0, b};
      q = prod >> FRAC_W;
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      r = q[63:0];
      if (a[63]) r = -r - ((prod[FRAC_W-1:0] != 0) ? 64'sd1 : 64'sd0);
      return r;
   endfunction

   function automatic level_type clamp48(input logic signed [63:0] v);
      if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (v < -64'sh0000_8000_0000_0000) return 48'sh8000_0000_0000;
      return v[47:0];
   endfunction

   // apply one accepted item to the shadow state and give the new levels
   function automatic levels_type advance_genes(input gene_item_type it);
      levels_type r;
      level_type nm[3], np[3];
      logic signed [63:0] m, p, rep, sq, dm, dp;
      logic [127:0] num;
      logic [63:0] quo, mag;
      if (it.kind) begin
         mrna_lvl = it.lm;
         prot_lvl = it.lp;
         step_count = '0;
      end else begin
         for (int k = 0; k < 3; k++) begin
            m = mrna_lvl[k];
            p = prot_lvl[k];
            rep = prot_lvl[(k + 2) % 3];
            mag = rep[63] ? 64'd0 - rep : rep;
            sq = fx_mul(mag, mag);
            num = {81'd0, alpha} << FRAC_W;
            quo = 64'(num / {64'd0, (64'd1 << FRAC_W) + sq});
            dm = $signed(quo + {17'd0, alpha0}) - m;
            dp = fx_mul(m - p, {17'd0, beta});
            nm[k] = clamp48(m + fx_mul(dm, {27'd0, h_step}));
            np[k] = clamp48(p + fx_mul(dp, {27'd0, h_step}));
         end
         mrna_lvl = nm;
         prot_lvl = np;
         if (step_count != '1) step_count++;
      end
      r.idx = step_count;
      r.m = mrna_lvl;
      r.p = prot_lvl;
      return r;
   endfunction

   // driver: present queued items, idle at random, hold while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_levels.insert(expected_levels.size(), advance_genes(cur_item));
            quiet_cycles = 0;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               cur_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_kind <= cur_item.kind;
               req_load_mrna_a <= cur_item.lm[0];
               req_load_mrna_b <= cur_item.lm[1];
               req_load_mrna_c <= cur_item.lm[2];
               req_load_protein_a <= cur_item.lp[0];
               req_load_protein_b <= cur_item.lp[1];
               req_load_protein_c <= cur_item.lp[2];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      levels_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         quiet_cycles++;
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected result, step_index %0d", $realtime, rsp_step_index);
               errors++;
            end else begin
               e = expected_levels.pop_front();
               if (e.idx !== rsp_step_index) begin
                  $display("%0t: step_index expected %0d actual %0d", $realtime, e.idx,
                           rsp_step_index);
                  errors++;
               end
               if (e.m[0] !== rsp_mrna_a || e.m[1] !== rsp_mrna_b || e.m[2] !== rsp_mrna_c) begin
                  $display("%0t: mrna expected %h %h %h actual %h %h %h", $realtime,
                           e.m[0], e.m[1], e.m[2], rsp_mrna_a, rsp_mrna_b, rsp_mrna_c);
                  errors++;
               end
               if (e.p[0] !== rsp_protein_a || e.p[1] !== rsp_protein_b ||
                   e.p[2] !== rsp_protein_c) begin
                  $display("%0t: protein expected %h %h %h actual %h %h %h", $realtime,
                           e.p[0], e.p[1], e.p[2], rsp_protein_a, rsp_protein_b,
                           rsp_protein_c);
                  errors++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // random level: full range, realistic small, or a limit
   function automatic level_type rand_level();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(3))
         0, 1: return w[47:0];
         2: return level_type'({$urandom_range(255), 36'd0} | w[35:0]);
         default: return $urandom_range(1) ? 48'sh7FFF_FFFF_FFFF : 48'sh8000_0000_0000;
      endcase
   endfunction

   task automatic queue_item(input logic kind, input level_type lm0, input level_type lp0,
                             input logic fill_rand);
      gene_item_type it;
      it.kind = kind;
      for (int k = 0; k < 3; k++) begin
         it.lm[k] = fill_rand ? rand_level() : lm0;
         it.lp[k] = fill_rand ? rand_level() : lp0;
      end
      pending_items.insert(pending_items.size(), it);
   endtask

   // write all four registers back to back, valid held across writes
   task automatic program_regs(input logic [RATE_W-1:0] a, input logic [RATE_W-1:0] a0,
                               input logic [RATE_W-1:0] b, input logic [RATE_W-1:0] hs);
      logic [RATE_W-1:0] v[4];
      v = '{a, a0, b, hs};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= v[i];
         do @(posedge clock); while (!csr_ready);
         case (csr_index_type'(i))
            CSR_MAX_RATE:    alpha = v[i];
            CSR_LEAK_RATE:   alpha0 = v[i];
            CSR_DECAY_RATIO: beta = v[i];
            CSR_STEP_SIZE:   h_step = v[i][STEP_W-1:0];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || expected_levels.size() != 0);
   endtask

   initial begin
      mrna_lvl = '{48'sd0, MRNA_35_RST, MRNA_35_RST};
      prot_lvl = '{48'sd0, 48'sd0, 48'sd0};
      step_count = '0;
      alpha = MAX_RATE_RST;
      alpha0 = LEAK_RATE_RST;
      beta = DECAY_RATIO_RST;
      h_step = STEP_SIZE_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < 6; ph++) begin
         sender_idle_pct = (ph < 2) ? 22 : (ph < 4) ? 79 : 0;
         receiver_idle_pct = (ph < 2) ? 79 : (ph < 4) ? 22 : 0;
         case (ph)
            1: program_regs('1, '1, '1, '1);
            2: program_regs('0, '0, '0, '0);
            3: program_regs(RATE_W'($urandom), RATE_W'($urandom_range(1 << 30)),
                            RATE_W'($urandom), 47'd1 << FRAC_W);
            4: program_regs(RATE_W'({$urandom, $urandom}), RATE_W'({$urandom, $urandom}),
                            RATE_W'({$urandom, $urandom}), RATE_W'({$urandom, $urandom}));
            5: program_regs(MAX_RATE_RST, LEAK_RATE_RST, DECAY_RATIO_RST,
                            RATE_W'(STEP_SIZE_RST));
            default: ;
         endcase
         // directed: reset state, level limits, ignored load fields on a step
         if (ph == 0) begin
            queue_item(1'b0, '0, '0, 1'b0);
            queue_item(1'b0, 48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000, 1'b0);
            queue_item(1'b1, '0, '0, 1'b0);
            queue_item(1'b0, '0, '0, 1'b0);
            queue_item(1'b1, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 1'b0);
            queue_item(1'b0, '0, '0, 1'b0);
            queue_item(1'b0, '0, '0, 1'b0);
            queue_item(1'b1, 48'sh8000_0000_0000, 48'sh8000_0000_0000, 1'b0);
            queue_item(1'b0, '0, '0, 1'b0);
            queue_item(1'b0, '0, '0, 1'b0);
            queue_item(1'b1, 48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000, 1'b0);
            queue_item(1'b0, '0, '0, 1'b0);
            queue_item(1'b1, 48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF, 1'b0);
            queue_item(1'b0, 48'sh5555_5555_5555, 48'shAAAA_AAAA_AAAA, 1'b0);
            queue_item(1'b1, 48'sd3 << FRAC_W, 48'sd5 << FRAC_W, 1'b0);
            queue_item(1'b0, '0, '0, 1'b1);
            queue_item(1'b0, '0, '0, 1'b1);
         end
         // random: mostly steps from loaded states, some loads
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            queue_item($urandom_range(99) < 20, '0, '0, 1'b1);
         end
         wait_idle();
      end

      repeat (300) @(posedge clock);
      if (errors == 0 && expected_levels.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
